[rtl/rpe_pkg.sv]
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and codes for the RGBE pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_NEG  = 2'd2,
      ST_BAD  = 2'd3
   } status_type;

   localparam int unsigned QUEUE_DEPTH = 2;

   // One classified pixel waiting for the back end
   typedef struct packed {
      logic [31:0] red_bits;
      logic [31:0] green_bits;
      logic [31:0] blue_bits;
      logic [7:0]  biased;
      status_type  status;
      logic        line_end;
   } job_type;

endpackage

`default_nettype wire

[rtl/rpe_front.sv]
// ----------------------------------------------------------------------------
// rpe_front
// Classifies a pixel: picks the largest channel and the biased shared exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_front (
   input  wire logic [31:0]     red_bits,
   input  wire logic [31:0]     green_bits,
   input  wire logic [31:0]     blue_bits,
   input  wire logic            line_end,
   output rpe_pkg::job_type     job
);
   import rpe_pkg::*;

   // Ordering key: sign-magnitude turned into two's complement
   function automatic logic signed [32:0] order_key(input logic [31:0] b);
      logic signed [32:0] mag;
      mag = $signed({2'b00, b[30:0]});
      return b[31] ? -mag : mag;
   endfunction

   logic        nonfinite;
   logic [31:0] max_bits;
   logic [31:0] max_rg;
   logic [7:0]  max_ef;
   logic [22:0] max_mf;
   logic [8:0]  biased_wide;
   logic        out_range;

   // Spot infinity or NaN on any channel
   assign nonfinite = (red_bits[30:23] == 8'hFF) || (green_bits[30:23] == 8'hFF)
                    || (blue_bits[30:23] == 8'hFF);

   // Choose the largest channel, earlier channel winning a tie
   assign max_rg   = (order_key(red_bits) < order_key(green_bits)) ? green_bits : red_bits;
   assign max_bits = (order_key(max_rg) < order_key(blue_bits)) ? blue_bits : max_rg;
   assign max_ef   = max_bits[30:23];
   assign max_mf   = max_bits[22:0];

   // Work out 128 + e from the largest channel's exponent and mantissa
   always_comb begin
      out_range   = 1'b0;
      biased_wide = 9'd0;
      if (max_ef != 8'd0) begin
         if ((max_mf == 23'd0) && (max_ef >= 8'd127)) begin
            biased_wide = {1'b0, max_ef} + 9'd1;
         end else begin
            biased_wide = {1'b0, max_ef} + 9'd2;
         end
         out_range = biased_wide[8];
      end else begin
         // subnormal: leading one must sit in the top three bits
         if (max_mf[22]) begin
            biased_wide = 9'd2;
         end else if (max_mf[21]) begin
            biased_wide = 9'd1;
         end else begin
            biased_wide = 9'd0;
         end
         out_range = (max_mf[22:20] == 3'd0);
      end
   end

   // Assemble the job with its status
   always_comb begin
      job.red_bits   = red_bits;
      job.green_bits = green_bits;
      job.blue_bits  = blue_bits;
      job.line_end   = line_end;
      job.biased     = biased_wide[7:0];
      if (nonfinite) begin
         job.status = ST_BAD;
      end else if (max_bits[30:0] == 31'd0) begin
         job.status = ST_ZERO;
      end else if (max_bits[31]) begin
         job.status = ST_NEG;
      end else if (out_range) begin
         job.status = ST_BAD;
      end else begin
         job.status = ST_OK;
      end
   end

endmodule

`default_nettype wire

[rtl/rpe_queue.sv]
// ----------------------------------------------------------------------------
// rpe_queue
// Two-entry queue that decouples the classifier from the scaling stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rpe_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output rpe_pkg::job_type      pop_job,
   output logic                  not_empty
);
   import rpe_pkg::*;

   job_type    mem [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign pop_job   = mem[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue pushed while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

[rtl/rpe_back.sv]
// ----------------------------------------------------------------------------
// rpe_back
// Scales each channel by the shared exponent and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire rpe_pkg::job_type job,
   output logic                  job_take,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [31:0]           rsp_data,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);
   import rpe_pkg::*;

   // floor(x * 255 * 2^-n + 0.5), saturated to a byte
   function automatic logic [7:0] scale(input logic [31:0] b, input logic [7:0] biased);
      logic [7:0]         ef;
      logic [23:0]        sig;
      logic [31:0]        t;
      logic signed [9:0]  n;
      logic [40:0]        tr;
      logic [40:0]        v;
      logic [7:0]         res;
      ef  = b[30:23];
      sig = (ef == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
      t   = {sig, 8'd0} - {8'd0, sig};
      if (ef == 8'd0) begin
         n = $signed({2'b00, biased}) + 10'sd21;
      end else begin
         n = $signed({2'b00, biased}) - $signed({2'b00, ef}) + 10'sd22;
      end
      tr  = 41'd0;
      v   = 41'd0;
      res = 8'd0;
      if (b[31] || (sig == 24'd0) || (n > 10'sd40)) begin
         res = 8'd0;
      end else if (n < 10'sd0) begin
         res = 8'd255;
      end else if (n == 10'sd0) begin
         res = (t > 32'd255) ? 8'd255 : t[7:0];
      end else begin
         tr  = {9'd0, t} + (41'd1 << (n[5:0] - 6'd1));
         v   = tr >> n[5:0];
         res = (v > 41'd255) ? 8'd255 : v[7:0];
      end
      return res;
   endfunction

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;
   logic        load;

   assign load     = !valid_ff || rsp_ready;
   assign job_take = job_valid && load;

   // Compute the next result from the head job
   always_comb begin
      valid_in  = valid_ff;
      data_in   = data_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = job_valid;
         status_in = job.status;
         last_in   = job.line_end;
         if (job.status == ST_OK) begin
            data_in = {job.biased, scale(job.blue_bits, job.biased),
                       scale(job.green_bits, job.biased), scale(job.red_bits, job.biased)};
         end else begin
            data_in = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_data   = data_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(data_ff))
      else $error("result changed while stalled");
   a_zero_on_error : assert property (@(posedge clock) disable iff (reset)
      valid_ff && (status_ff != ST_OK) |-> data_ff == 32'd0)
      else $error("non-zero bytes with error status");
   a_take_needs_room : assert property (@(posedge clock) disable iff (reset)
      job_take |-> !valid_ff || rsp_ready)
      else $error("job taken without room");

endmodule

`default_nettype wire

[rtl/rgbe_pixel_encode.sv]
// Path: an accepted pixel is written to a queue entry, then to the result register.
// Throughput: one pixel per cycle unless the receiver stalls, set by the scaling stage.
// A two-entry queue between classifier and scaler absorbs output stalls.
// Reset: synchronous, active high; clears queue and result valid, no
// clearing pass.
// ----------------------------------------------------------------------------
// rgbe_pixel_encode
// Converts float RGB pixels to shared-exponent RGBE bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbe_pixel_encode (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // red_bits, green_bits, blue_bits
   input  wire logic        req_tlast,   // line_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // red_mant, green_mant, blue_mant, shared_exp
   output logic [1:0]       rsp_tuser,   // status
   output logic             rsp_tlast    // line_end_out
);
   import rpe_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   logic    q_push;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   rpe_front u_front (
      .red_bits   (req_tdata[31:0]),
      .green_bits (req_tdata[63:32]),
      .blue_bits  (req_tdata[95:64]),
      .line_end   (req_tlast),
      .job        (front_job)
   );

   rpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_job   (head_job),
      .not_empty (q_not_empty)
   );

   rpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_not_empty),
      .job        (head_job),
      .job_take   (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

[sim/tb_rgbe_pixel_encode.sv]
// ----------------------------------------------------------------------------
// tb_rgbe_pixel_encode
// Self-checking bench for the RGBE pixel encoder: directed corner pixels,
// then random pixels with random stalls on both sides, checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

import rpe_pkg::*;

typedef struct packed {
   logic [7:0] red_mant;
   logic [7:0] green_mant;
   logic [7:0] blue_mant;
   logic [7:0] shared_exp;
   status_type status;
   logic       line_end;
} rgbe_pixel_type;

// In-order store of encoded pixels awaiting comparison
class rgbe_scoreboard;
   rgbe_pixel_type pending[$];
   int errors = 0;

   static function longint signed order_key(logic [31:0] b);
      longint signed mag;
      mag = longint'(b[30:0]);
      return b[31] ? -mag : mag;
   endfunction

   static function logic [7:0] scale_channel(logic [31:0] b, int e);
      logic [63:0] sig, t, v;
      int q, sh, n;
      if (b[31]) return 8'd0;
      if (b[30:23] == 8'd0) begin
         sig = {41'd0, b[22:0]};
         q = -149;
      end else begin
         sig = {40'd0, 1'b1, b[22:0]};
         q = int'(b[30:23]) - 150;
      end
      if (sig == 0) return 8'd0;
      sh = q - e;
      t = sig * 64'd255;
      if (sh >= 0) begin
         if (sh > 8) return 8'd255;
         v = t << sh;
      end else begin
         n = -sh;
         if (n > 40) return 8'd0;
         v = (t + (64'd1 << (n - 1))) >> n;
      end
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   static function rgbe_pixel_type encode(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                          logic le);
      rgbe_pixel_type o;
      logic [31:0] ch[3];
      logic [31:0] mx;
      longint signed kmax;
      int p, e, top, biased;
      bit pow2;
      ch[0] = r; ch[1] = g; ch[2] = b;
      o = '0;
      o.line_end = le;
      // Non-finite check comes first
      for (int i = 0; i < 3; i++)
         if (ch[i][30:23] == 8'hFF) begin
            o.status = ST_BAD;
            return o;
         end
      mx = ch[0];
      kmax = order_key(ch[0]);
      for (int i = 1; i < 3; i++)
         if (kmax < order_key(ch[i])) begin
            mx = ch[i];
            kmax = order_key(ch[i]);
         end
      if (kmax == 0) begin
         o.status = ST_ZERO;
         return o;
      end
      if (kmax < 0) begin
         o.status = ST_NEG;
         return o;
      end
      if (mx[30:23] != 0) begin
         p = int'(mx[30:23]) - 127;
         pow2 = (mx[22:0] == 0);
      end else begin
         top = 22;
         while (top > 0 && !mx[top]) top--;
         p = top - 149;
         pow2 = (mx[22:0] == (23'd1 << top));
      end
      e = (pow2 && p >= 0) ? p : p + 1;
      biased = 128 + e;
      if (biased < 0 || biased > 255) begin
         o.status = ST_BAD;
         return o;
      end
      o.red_mant = scale_channel(r, e);
      o.green_mant = scale_channel(g, e);
      o.blue_mant = scale_channel(b, e);
      o.shared_exp = biased[7:0];
      o.status = ST_OK;
      return o;
   endfunction

   function void note_pixel(logic [95:0] d, logic le);
      pending.push_back(encode(d[31:0], d[63:32], d[95:64], le));
   endfunction

   function void check_result(logic [31:0] d, logic [1:0] st, logic le);
      rgbe_pixel_type want, got;
      got.red_mant   = d[7:0];
      got.green_mant = d[15:8];
      got.blue_mant  = d[23:16];
      got.shared_exp = d[31:24];
      got.status     = status_type'(st);
      got.line_end   = le;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.red_mant !== want.red_mant)
         $display("%0t: red_mant exp %h got %h", $time, want.red_mant, got.red_mant);
      if (got.green_mant !== want.green_mant)
         $display("%0t: green_mant exp %h got %h", $time, want.green_mant, got.green_mant);
      if (got.blue_mant !== want.blue_mant)
         $display("%0t: blue_mant exp %h got %h", $time, want.blue_mant, got.blue_mant);
      if (got.shared_exp !== want.shared_exp)
         $display("%0t: shared_exp exp %h got %h", $time, want.shared_exp, got.shared_exp);
      if (got.status !== want.status)
         $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
      if (got.line_end !== want.line_end)
         $display("%0t: line_end exp %b got %b", $time, want.line_end, got.line_end);
      if (got !== want) errors++;
   endfunction
endclass

module tb_rgbe_pixel_encode;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // red_bits, green_bits, blue_bits
   logic        req_tlast = 0;    // line_end
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;        // red_mant, green_mant, blue_mant, shared_exp
   logic [1:0]  rsp_tuser;        // status
   logic        rsp_tlast;        // line_end_out

   rgbe_scoreboard pixels = new();
   bit  hold_sink = 0;
   bit  sender_done = 0;
   int  quiet_cycles = 0;

   rgbe_pixel_encode uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Check results and count quiet cycles for the watchdog
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         pixels.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: random stalls per result, or a long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_sink) begin
            rsp_tready <= 0;
            repeat (40) @(posedge clock);
            hold_sink = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one pixel and hold it until transferred
   task automatic send_pixel(logic [95:0] d, logic le, int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      req_tlast <= le;
      do @(posedge clock); while (!req_tready);
      pixels.note_pixel(d, le);
   endtask

   function automatic logic [31:0] rand_float();
      logic [31:0] f;
      f = $urandom();
      case ($urandom_range(0, 7))
         0, 1, 2: f[30:23] = 8'(8'd127 + $urandom_range(0, 8) - 4);  // near unity
         3:       f[30:23] = 8'($urandom_range(0, 2));               // subnormal edge
         4:       f[30:23] = 8'($urandom_range(250, 255));           // top end
         5:       f[30:23] = 8'($urandom_range(100, 160));
         6:       f[22:0] = ($urandom_range(0, 1)) ? 23'd0 : f[22:0];
         default: ;
      endcase
      if ($urandom_range(0, 2) != 0) f[31] = 0;
      return f;
   endfunction

   // Directed corners: zeros, negatives, infinities, NaN, powers of two,
   // subnormals, half-way rounding, range limits
   logic [31:0] corners[] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F00_0000,
                              32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hBF80_0000,
                              32'h0000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF, 32'h4300_0000,
                              32'h3F7F_FFFF, 32'h0040_0000, 32'hFFFF_FFFF, 32'h3B80_0000};

   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (corners[i])
         send_pixel({32'h3E80_0000, corners[(i + 3) % corners.size()], corners[i]},
                    i[0], 0);
      send_pixel({32'h0000_0000, 32'h8000_0000, 32'h0000_0000}, 1, 0);
      send_pixel({32'hBF00_0000, 32'hC000_0000, 32'hBF80_0000}, 0, 0);
      send_pixel({32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000}, 1, 0);
      send_pixel({32'h3C00_0000, 32'h3F00_0000, 32'h3B00_0000}, 0, 0);
      send_pixel({96{1'b1}}, 1, 0);
      // Long receiver hold-off while the sender keeps offering
      hold_sink = 1;
      for (int k = 0; k < 12; k++)
         send_pixel({rand_float(), rand_float(), rand_float()}, 1'($urandom_range(0, 1)), 0);
      for (int k = 0; k < 1400; k++) begin
         n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
         if ($urandom_range(0, 20) == 0)
            send_pixel({64'd0, $urandom()} ^ {$urandom(), $urandom(), $urandom()},
                       1'($urandom_range(0, 1)), n);
         else
            send_pixel({rand_float(), rand_float(), rand_float()},
                       1'($urandom_range(0, 1)), n);
         // Pause the sender until the pipe drains
         if (k == 700) begin
            req_tvalid <= 0;
            while (pixels.pending.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      while (pixels.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pixels.errors == 0 && pixels.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

`default_nettype wire
